FILE: src/klx_pkg.sv
package klx_pkg;

  // Width of the byte position, word start and word length counters.
  localparam int unsigned PosW = 32;
  // Width of the token offset and length fields on the result word.
  localparam int unsigned FieldW = 32;
  // Depth of the queue between the classifier and the scanner.
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  // Depth of the result buffer at the scanner output.
  localparam int unsigned OutDepth = 4;
  localparam int unsigned OutPtrW = $clog2(OutDepth);

  // Token kinds.
  localparam logic [3:0] TOK_SEMI      = 4'd0;
  localparam logic [3:0] TOK_LBRACE    = 4'd1;
  localparam logic [3:0] TOK_RBRACE    = 4'd2;
  localparam logic [3:0] TOK_LPAREN    = 4'd3;
  localparam logic [3:0] TOK_RPAREN    = 4'd4;
  localparam logic [3:0] TOK_ASSIGN    = 4'd5;
  localparam logic [3:0] TOK_CLASS     = 4'd6;
  localparam logic [3:0] TOK_STATIC    = 4'd7;
  localparam logic [3:0] TOK_RETURN    = 4'd8;
  localparam logic [3:0] TOK_VOID      = 4'd9;
  localparam logic [3:0] TOK_INT       = 4'd10;
  localparam logic [3:0] TOK_IDENT     = 4'd11;
  localparam logic [3:0] TOK_END       = 4'd12;
  localparam logic [3:0] TOK_STRAY     = 4'd13;
  localparam logic [3:0] TOK_OPEN_CMT  = 4'd14;

  // Characters the classifier looks for.
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_ASSIGN  = 8'h3D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_STAR    = 8'h2A;

  // Keyword spellings, first bytes packed big-endian into 48 bits.
  localparam logic [47:0] KW_CLASS  = 48'h00636C617373;
  localparam logic [47:0] KW_STATIC = 48'h737461746963;
  localparam logic [47:0] KW_RETURN = 48'h72657475726E;
  localparam logic [47:0] KW_VOID   = 48'h0000766F6964;
  localparam logic [47:0] KW_INT    = 48'h000000696E74;

  // One input word.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_text;
  } src_word_t;

  // One result word.
  typedef struct packed {
    logic [3:0]        token_kind;
    logic [FieldW-1:0] text_start;
    logic [FieldW-1:0] text_length;
    logic              last_of_run;
  } tok_word_t;

  // Classified byte as it travels from the front to the scanner.
  typedef struct packed {
    logic       eot;
    logic       is_punct;
    logic [3:0] punct_kind;
    logic       is_space;
    logic       is_slash;
    logic       is_star;
    logic       is_newline;
    logic [7:0] byte_value;
  } cls_t;

  // Bring a counter value to the width of a result field.
  function automatic logic [FieldW-1:0] to_field(input logic [PosW-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[FieldW-1:0];
  endfunction

endpackage

FILE: src/keyword_token_lexer_unit.sv
// Byte-serial lexer for a small C-like language. Each source word carries
// one byte or the end marker and is taken at up to one per clock while the
// four-deep queue from the classifier has room; the scanner retires one byte
// per clock into a four-entry result buffer while it has room for two results.
// A byte yields no token, one, or two (a word closed by a punctuator, or the
// end marker after a word or an open slash or block comment); the token
// channel emits one token per clock while not stalled. The first word is
// accepted in the cycle after reset; a byte is registered in the queue and
// its tokens in the result buffer before they appear on the token channel.
module keyword_token_lexer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  klx_pkg::src_word_t src_word,
  output logic               tok_valid,
  input  logic               tok_stall,
  output klx_pkg::tok_word_t tok_word
);
  import klx_pkg::*;

  logic push, queue_full, pop, head_valid;
  cls_t push_word, head_word;

  klx_front u_front (
    .src_valid  (src_valid),
    .src_stall  (src_stall),
    .src_word   (src_word),
    .push       (push),
    .push_word  (push_word),
    .queue_full (queue_full)
  );

  klx_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_word  (push_word),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  klx_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_word  (head_word),
    .pop        (pop),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_word   (tok_word)
  );

endmodule

FILE: src/klx_front.sv
module klx_front (
  input  logic               src_valid,
  output logic               src_stall,
  input  klx_pkg::src_word_t src_word,
  output logic               push,
  output klx_pkg::cls_t      push_word,
  input  logic               queue_full
);
  import klx_pkg::*;

  // The front takes a word whenever the queue has room.
  assign src_stall = queue_full;
  assign push      = src_valid && !queue_full;

  // Classify the byte so the scanner only tests flags.
  always_comb begin
    logic [7:0] b;
    b = src_word.byte_value;
    push_word            = '0;
    push_word.eot        = src_word.end_of_text;
    push_word.byte_value = b;
    push_word.is_space   = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_NEWLINE);
    push_word.is_slash   = (b == CH_SLASH);
    push_word.is_star    = (b == CH_STAR);
    push_word.is_newline = (b == CH_NEWLINE);
    push_word.is_punct   = 1'b1;
    unique case (b)
      CH_SEMI:   push_word.punct_kind = TOK_SEMI;
      CH_LBRACE: push_word.punct_kind = TOK_LBRACE;
      CH_RBRACE: push_word.punct_kind = TOK_RBRACE;
      CH_LPAREN: push_word.punct_kind = TOK_LPAREN;
      CH_RPAREN: push_word.punct_kind = TOK_RPAREN;
      CH_ASSIGN: push_word.punct_kind = TOK_ASSIGN;
      default: begin
        push_word.is_punct   = 1'b0;
        push_word.punct_kind = TOK_SEMI;
      end
    endcase
  end

endmodule

FILE: src/klx_queue.sv
module klx_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  klx_pkg::cls_t push_word,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output klx_pkg::cls_t head_word
);
  import klx_pkg::*;

  cls_t                mem [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   count;

  assign full       = (count == (QueuePtrW+1)'(QueueDepth));
  assign head_valid = (count != '0);
  assign head_word  = mem[rd_ptr];

  // Storage needs no reset; only the pointers and the count do.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/klx_back.sv
module klx_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  klx_pkg::cls_t      head_word,
  output logic               pop,
  output logic               tok_valid,
  input  logic               tok_stall,
  output klx_pkg::tok_word_t tok_word
);
  import klx_pkg::*;

  typedef enum logic [5:0] {
    M_NORMAL = 6'b000001,
    M_SLASH  = 6'b000010,
    M_LINE   = 6'b000100,
    M_BLOCK  = 6'b001000,
    M_STAR   = 6'b010000,
    M_ERROR  = 6'b100000
  } mode_t;

  mode_t           mode, mode_next;
  logic [PosW-1:0] position, position_next;
  logic [PosW-1:0] word_start, word_start_next;
  logic [PosW-1:0] word_length, word_length_next;
  logic [47:0]     word_prefix, word_prefix_next;

  tok_word_t         out_mem [OutDepth];
  logic [OutPtrW-1:0] out_wr, out_rd;
  logic [OutPtrW:0]   out_count, out_count_next;

  tok_word_t word_tok, lead, tail, res0, res1;
  logic      have_word, lead_valid, tail_valid;
  logic [1:0] n_res;
  logic      out_pop;

  // The scanner takes a byte only when the buffer has room for two results.
  assign pop = head_valid && (out_count <= (OutPtrW+1)'(OutDepth - 2));

  // Token for the word collected so far, keyword or identifier.
  always_comb begin
    word_tok = '0;
    have_word = (word_length != '0);
    if (word_length == PosW'(5) && word_prefix == KW_CLASS) begin
      word_tok.token_kind = TOK_CLASS;
    end else if (word_length == PosW'(6) && word_prefix == KW_STATIC) begin
      word_tok.token_kind = TOK_STATIC;
    end else if (word_length == PosW'(6) && word_prefix == KW_RETURN) begin
      word_tok.token_kind = TOK_RETURN;
    end else if (word_length == PosW'(4) && word_prefix == KW_VOID) begin
      word_tok.token_kind = TOK_VOID;
    end else if (word_length == PosW'(3) && word_prefix == KW_INT) begin
      word_tok.token_kind = TOK_INT;
    end else begin
      word_tok.token_kind  = TOK_IDENT;
      word_tok.text_start  = to_field(word_start);
      word_tok.text_length = to_field(word_length);
    end
  end

  // Scanner step: up to a leading token (usually a finished word) and a tail token.
  always_comb begin
    mode_next        = mode;
    position_next    = position + 1'b1;
    word_start_next  = word_start;
    word_length_next = word_length;
    word_prefix_next = word_prefix;
    lead_valid = 1'b0;
    lead       = word_tok;
    tail_valid = 1'b0;
    tail       = '0;

    if (head_word.eot) begin
      tail_valid = 1'b1;
      tail.token_kind = TOK_END;
      unique case (mode)
        M_NORMAL: lead_valid = have_word;
        M_SLASH: begin
          lead_valid = 1'b1;
          lead = '0;
          lead.token_kind = TOK_STRAY;
        end
        M_BLOCK, M_STAR: begin
          lead_valid = 1'b1;
          lead = '0;
          lead.token_kind = TOK_OPEN_CMT;
        end
        default: lead_valid = 1'b0;
      endcase
      mode_next        = M_NORMAL;
      position_next    = '0;
      word_start_next  = '0;
      word_length_next = '0;
      word_prefix_next = '0;
    end else begin
      unique case (mode)
        M_NORMAL: begin
          if (head_word.is_punct || head_word.is_space || head_word.is_slash) begin
            lead_valid       = have_word;
            word_start_next  = '0;
            word_length_next = '0;
            word_prefix_next = '0;
            if (head_word.is_punct) begin
              tail_valid = 1'b1;
              tail.token_kind = head_word.punct_kind;
            end
            if (head_word.is_slash) begin
              mode_next = M_SLASH;
            end
          end else begin
            if (!have_word) begin
              word_start_next = position;
            end
            if (word_length < PosW'(6)) begin
              word_prefix_next = {word_prefix[39:0], head_word.byte_value};
            end
            if (word_length != '1) begin
              word_length_next = word_length + 1'b1;
            end
          end
        end
        M_SLASH: begin
          if (head_word.is_slash) begin
            mode_next = M_LINE;
          end else if (head_word.is_star) begin
            mode_next = M_BLOCK;
          end else begin
            tail_valid = 1'b1;
            tail.token_kind = TOK_STRAY;
            mode_next = M_ERROR;
          end
        end
        M_LINE: begin
          if (head_word.is_newline) begin
            mode_next = M_NORMAL;
          end
        end
        M_BLOCK: begin
          if (head_word.is_star) begin
            mode_next = M_STAR;
          end
        end
        M_STAR: begin
          if (head_word.is_slash) begin
            mode_next = M_NORMAL;
          end else if (!head_word.is_star) begin
            mode_next = M_BLOCK;
          end
        end
        default: mode_next = M_ERROR;
      endcase
    end

    // Pack the results in order and mark the final one.
    res0 = lead_valid ? lead : tail;
    res1 = tail;
    n_res = 2'(lead_valid) + 2'(tail_valid);
    res0.last_of_run = (n_res == 2'd1);
    res1.last_of_run = 1'b1;
  end

  // Scanner state advances with every byte taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_NORMAL;
      position    <= '0;
      word_start  <= '0;
      word_length <= '0;
      word_prefix <= '0;
    end else if (pop) begin
      mode        <= mode_next;
      position    <= position_next;
      word_start  <= word_start_next;
      word_length <= word_length_next;
      word_prefix <= word_prefix_next;
    end
  end

  // Result buffer between the scanner and the token channel.
  assign tok_valid = (out_count != '0);
  assign tok_word  = out_mem[out_rd];
  assign out_pop   = tok_valid && !tok_stall;

  always_comb begin
    out_count_next = out_count - (OutPtrW+1)'(out_pop);
    if (pop) begin
      out_count_next = out_count_next + (OutPtrW+1)'(n_res);
    end
  end

  always_ff @(posedge clk) begin
    if (pop && n_res != 2'd0) begin
      out_mem[out_wr] <= res0;
      if (n_res == 2'd2) begin
        out_mem[out_wr + 1'b1] <= res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wr    <= '0;
      out_rd    <= '0;
      out_count <= '0;
    end else begin
      if (pop) begin
        out_wr <= out_wr + OutPtrW'(n_res);
      end
      if (out_pop) begin
        out_rd <= out_rd + 1'b1;
      end
      out_count <= out_count_next;
    end
  end

endmodule

FILE: src/klx_checker.sv
module klx_checker (
  input logic               clk,
  input logic               rst,
  input logic               src_valid,
  input logic               src_stall,
  input klx_pkg::src_word_t src_word,
  input logic               tok_valid,
  input logic               tok_stall,
  input klx_pkg::tok_word_t tok_word
);
  import klx_pkg::*;

  // A stalled source word holds until it is taken.
  a_src_hold: assert property (@(posedge clk) disable iff (rst)
    src_valid && src_stall |=> src_valid && $stable(src_word))
    else $error("source word changed while stalled");

  // A stalled token word holds until it is taken.
  a_tok_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_stall |=> tok_valid && $stable(tok_word))
    else $error("token word changed while stalled");

  // Only identifiers carry an offset and a length.
  a_plain_zero: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_word.token_kind != TOK_IDENT |->
      tok_word.text_start == '0 && tok_word.text_length == '0)
    else $error("non-identifier token with offset or length");

  // An identifier is never empty.
  a_ident_len: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_word.token_kind == TOK_IDENT |-> tok_word.text_length != '0)
    else $error("empty identifier");

  // The end token always closes its run.
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_word.token_kind == TOK_END |-> tok_word.last_of_run)
    else $error("end token not last of its run");

endmodule

bind keyword_token_lexer_unit klx_checker u_klx_checker (
  .clk       (clk),
  .rst       (rst),
  .src_valid (src_valid),
  .src_stall (src_stall),
  .src_word  (src_word),
  .tok_valid (tok_valid),
  .tok_stall (tok_stall),
  .tok_word  (tok_word)
);

FILE: bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import klx_pkg::*;

  localparam int unsigned TotalWords = 620;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned MaxPrinted = 100;
  localparam int unsigned LongHold = 300;

  typedef enum logic [2:0] {
    SCAN_NORMAL,
    SCAN_SLASH,
    SCAN_LINE,
    SCAN_BLOCK,
    SCAN_STAR,
    SCAN_ERROR
  } scan_mode_e;

  // Mirror of the lexer: tracks the scan state and keeps the tokens still owed.
  class token_forecast;
    tok_word_t pending_tokens[$];
    tok_word_t step_tokens[$];
    int unsigned mismatches;
    scan_mode_e mode;
    logic [PosW-1:0] position;
    logic [PosW-1:0] word_start;
    logic [PosW-1:0] word_length;
    logic [47:0] word_prefix;

    function new();
      mismatches = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      mode = SCAN_NORMAL;
      position = '0;
      word_start = '0;
      word_length = '0;
      word_prefix = '0;
    endfunction

    function void add_token(logic [3:0] kind, logic [PosW-1:0] start, logic [PosW-1:0] len);
      tok_word_t t;
      t.token_kind = kind;
      t.text_start = start[FieldW-1:0];
      t.text_length = len[FieldW-1:0];
      t.last_of_run = 1'b0;
      step_tokens.push_back(t);
    endfunction

    // A keyword needs both the exact length and the same leading bytes.
    function logic [3:0] word_kind();
      if (word_length == 5 && word_prefix == 48'h00636C617373) return TOK_CLASS;
      if (word_length == 6 && word_prefix == 48'h737461746963) return TOK_STATIC;
      if (word_length == 6 && word_prefix == 48'h72657475726E) return TOK_RETURN;
      if (word_length == 4 && word_prefix == 48'h0000766F6964) return TOK_VOID;
      if (word_length == 3 && word_prefix == 48'h000000696E74) return TOK_INT;
      return TOK_IDENT;
    endfunction

    function void close_word();
      logic [3:0] kind;
      if (word_length != 0) begin
        kind = word_kind();
        if (kind == TOK_IDENT) begin
          add_token(kind, word_start, word_length);
        end else begin
          add_token(kind, '0, '0);
        end
      end
      word_start = '0;
      word_length = '0;
      word_prefix = '0;
    endfunction

    function void punct(logic [3:0] kind);
      close_word();
      add_token(kind, '0, '0);
    endfunction

    // Works out the tokens caused by one accepted source word.
    function void take_word(src_word_t w);
      logic [7:0] b;
      b = w.byte_value;
      step_tokens.delete();
      if (w.end_of_text) begin
        case (mode)
          SCAN_NORMAL: close_word();
          SCAN_SLASH: add_token(TOK_STRAY, '0, '0);
          SCAN_BLOCK, SCAN_STAR: add_token(TOK_OPEN_CMT, '0, '0);
          default: ;
        endcase
        add_token(TOK_END, '0, '0);
        clear_scan();
      end else begin
        case (mode)
          SCAN_NORMAL: begin
            case (b)
              CH_SEMI: punct(TOK_SEMI);
              CH_LBRACE: punct(TOK_LBRACE);
              CH_RBRACE: punct(TOK_RBRACE);
              CH_LPAREN: punct(TOK_LPAREN);
              CH_RPAREN: punct(TOK_RPAREN);
              CH_ASSIGN: punct(TOK_ASSIGN);
              CH_SPACE, CH_TAB, CH_NEWLINE: close_word();
              CH_SLASH: begin
                // The word ends before the slash is resolved.
                close_word();
                mode = SCAN_SLASH;
              end
              default: begin
                if (word_length == 0) word_start = position;
                if (word_length < 6) word_prefix = {word_prefix[39:0], b};
                if (word_length != '1) word_length = word_length + 1'b1;
              end
            endcase
          end
          SCAN_SLASH: begin
            if (b == CH_SLASH) begin
              mode = SCAN_LINE;
            end else if (b == CH_STAR) begin
              mode = SCAN_BLOCK;
            end else begin
              add_token(TOK_STRAY, '0, '0);
              mode = SCAN_ERROR;
            end
          end
          SCAN_LINE: begin
            if (b == CH_NEWLINE) mode = SCAN_NORMAL;
          end
          SCAN_BLOCK: begin
            if (b == CH_STAR) mode = SCAN_STAR;
          end
          SCAN_STAR: begin
            if (b == CH_SLASH) begin
              mode = SCAN_NORMAL;
            end else if (b != CH_STAR) begin
              mode = SCAN_BLOCK;
            end
          end
          default: mode = SCAN_ERROR;
        endcase
        position = position + 1'b1;
      end
      if (step_tokens.size() != 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
      foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MaxPrinted) $display("%0t: %s", $time, msg);
    endfunction

    // Compares one accepted token with the oldest one owed.
    function void match_token(tok_word_t got);
      tok_word_t want;
      if (pending_tokens.size() == 0) begin
        flag($sformatf("expected no token, got kind %0d start %0d length %0d last %0b",
                       got.token_kind, got.text_start, got.text_length, got.last_of_run));
        return;
      end
      want = pending_tokens.pop_front();
      if (got.token_kind !== want.token_kind)
        flag($sformatf("token_kind expected %0d got %0d", want.token_kind, got.token_kind));
      if (got.text_start !== want.text_start)
        flag($sformatf("text_start expected %0d got %0d", want.text_start, got.text_start));
      if (got.text_length !== want.text_length)
        flag($sformatf("text_length expected %0d got %0d", want.text_length, got.text_length));
      if (got.last_of_run !== want.last_of_run)
        flag($sformatf("last_of_run expected %0b got %0b", want.last_of_run, got.last_of_run));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic src_valid = 1'b0;
  logic src_stall;
  src_word_t src_word = '0;
  logic tok_valid;
  logic tok_stall = 1'b0;
  tok_word_t tok_word;

  token_forecast forecast;
  bit long_hold_req = 1'b0;
  int unsigned burst_left = 0;
  int unsigned words_sent = 0;
  int unsigned cycle_count = 0;
  logic [7:0] source_text[$];

  string keywords[5] = '{"class", "static", "return", "void", "int"};
  logic [7:0] punct_chars[6] = '{CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_ASSIGN};
  logic [7:0] blank_chars[3] = '{CH_SPACE, CH_TAB, CH_NEWLINE};

  keyword_token_lexer_unit DUT (
    .clk(clk),
    .rst(rst),
    .src_valid(src_valid),
    .src_stall(src_stall),
    .src_word(src_word),
    .tok_valid(tok_valid),
    .tok_stall(tok_stall),
    .tok_word(tok_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Every token word taken by the receiver is checked here.
  always @(posedge clk) begin
    if (!rst && tok_valid === 1'b1 && tok_stall === 1'b0) forecast.match_token(tok_word);
  end

  // Receiver stall pattern, with one long hold-off that backs up the block.
  initial begin : tok_stall_pattern
    int unsigned span;
    int unsigned style;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      span = $urandom_range(4, 40);
      style = $urandom_range(0, 3);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        style = 4;
        span = LongHold;
      end
      repeat (span) begin
        case (style)
          0: tok_stall <= 1'b0;
          1: tok_stall <= ($urandom_range(0, 1) == 1);
          2: tok_stall <= ~tok_stall;
          3: tok_stall <= ($urandom_range(0, 7) == 0);
          default: tok_stall <= 1'b1;
        endcase
        @(posedge clk);
      end
    end
  end

  // Offers one word in bursts separated by random gaps.
  task automatic offer_word(src_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    src_word <= w;
    src_valid <= 1'b1;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    forecast.take_word(w);
    words_sent++;
  endtask

  task automatic send_text();
    src_word_t w;
    foreach (source_text[i]) begin
      w.byte_value = source_text[i];
      w.end_of_text = 1'b0;
      offer_word(w);
    end
    source_text.delete();
  endtask

  // The end marker carries a random byte that the block must ignore.
  task automatic send_end();
    src_word_t w;
    w.byte_value = 8'($urandom_range(0, 255));
    w.end_of_text = 1'b1;
    offer_word(w);
  endtask

  function automatic void add_string(string s);
    foreach (s[i]) source_text.push_back(s[i]);
  endfunction

  function automatic bit is_separator(logic [7:0] b);
    case (b)
      CH_SEMI, CH_LBRACE, CH_RBRACE, CH_LPAREN, CH_RPAREN, CH_ASSIGN,
      CH_SPACE, CH_TAB, CH_NEWLINE, CH_SLASH: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // A byte that extends a word: mostly lowercase letters, sometimes any other non-separator byte.
  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(8'h61, 8'h7A));
    do b = 8'($urandom_range(0, 255)); while (is_separator(b));
    return b;
  endfunction

  // Comment text, rich in stars; a line comment body holds no newline.
  function automatic void add_comment_body(bit line);
    logic [7:0] b;
    repeat ($urandom_range(0, 8)) begin
      b = ($urandom_range(0, 2) == 0) ? CH_STAR : 8'($urandom_range(0, 255));
      if (line && b == CH_NEWLINE) b = CH_SPACE;
      source_text.push_back(b);
    end
  endfunction

  function automatic void add_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 20)) begin
      case ($urandom_range(0, 5))
        0, 1: b = CH_SLASH;
        2: b = CH_STAR;
        default: b = 8'($urandom_range(0, 255));
      endcase
      source_text.push_back(b);
    end
  endfunction

  // One lexical piece of a well-formed text, then maybe a separator.
  function automatic void add_piece();
    string s;
    int unsigned idx;
    int unsigned variant;
    s = keywords[$urandom_range(0, 4)];
    case ($urandom_range(0, 9))
      0, 1: add_string(s);
      2: begin
        // Near misses of a keyword.
        variant = $urandom_range(0, 3);
        case (variant)
          0: s = s.substr(0, s.len() - 2);
          1: s = {s, "s"};
          2: begin
            idx = $urandom_range(0, s.len() - 1);
            s[idx] = s[idx] ^ 8'h20;
          end
          default: ;
        endcase
        add_string(s);
        if (variant == 3) source_text.push_back(8'h00);
      end
      3, 4: begin
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6))
          source_text.push_back(word_byte());
      end
      5: source_text.push_back(punct_chars[$urandom_range(0, 5)]);
      6: source_text.push_back(blank_chars[$urandom_range(0, 2)]);
      7: begin
        add_string("//");
        add_comment_body(1'b1);
        source_text.push_back(CH_NEWLINE);
      end
      8: begin
        add_string("/*");
        add_comment_body(1'b0);
        add_string("*/");
      end
      default: add_string(s.substr(0, $urandom_range(0, s.len() - 1)));
    endcase
    case ($urandom_range(0, 3))
      0: source_text.push_back(CH_SPACE);
      1: source_text.push_back(punct_chars[$urandom_range(0, 5)]);
      2: source_text.push_back(blank_chars[$urandom_range(0, 2)]);
      default: ;
    endcase
  endfunction

  // Mostly well-formed texts; the rest end badly or are noise.
  task automatic send_program();
    int unsigned ending;
    logic [7:0] b;
    ending = $urandom_range(0, 9);
    if (ending == 9) begin
      add_noise();
    end else begin
      repeat ($urandom_range(1, 10)) add_piece();
      case (ending)
        5: source_text.push_back(CH_SLASH);
        6: begin
          add_string("/*");
          add_comment_body(1'b0);
        end
        7: begin
          do b = 8'($urandom_range(0, 255)); while (b == CH_SLASH || b == CH_STAR);
          source_text.push_back(CH_SLASH);
          source_text.push_back(b);
          add_noise();
        end
        8: begin
          add_string("//");
          add_comment_body(1'b1);
        end
        default: ;
      endcase
    end
    send_text();
    send_end();
  endtask

  initial begin : stimulus
    forecast = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Keyword, identifier, every punctuator, extreme bytes in a word that a
    // slash closes, and a slash left open at the end marker.
    add_string("int a;{}()=");
    source_text.push_back(8'h00);
    source_text.push_back(8'hFF);
    source_text.push_back(CH_SLASH);
    send_text();
    send_end();
    // Stray slash, then error mode until the end marker.
    add_string("/x");
    send_text();
    send_end();
    // Block comment still open at the end marker.
    add_string("/*");
    send_text();
    send_end();
    // Line comment running into the end marker.
    add_string("//");
    send_text();
    send_end();

    long_hold_req = 1'b1;
    while (words_sent < TotalWords) send_program();
    src_valid <= 1'b0;

    while (forecast.pending_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (forecast.mismatches == 0 && forecast.pending_tokens.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
